FILE: rtl/rhr_pkg.sv
// Package for the RGB hue rotation pipeline: widths, fixed-point constants and sector codes.
package rhr_pkg;

    localparam int PIX_W     = 8;
    localparam int OFF_W     = 14;
    localparam int HUE_W     = 13;
    localparam int SAT_W     = 16;
    localparam int DIV_STEPS = 17;
    localparam int DIV_W     = 26;
    localparam int DVS_W     = PIX_W + 1;
    localparam int CQ_W      = PIX_W + SAT_W;
    localparam int W_W       = 10;
    localparam int PROD_W    = 34;
    localparam int SUM_W     = PROD_W + 1;
    localparam int Z_W       = 13;
    localparam int RCP_W     = 13;

    localparam logic [15:0] HUE_FULL   = 16'd5760;
    localparam logic [15:0] HUE_WRAP   = 16'd11520;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [W_W-1:0]   SECT_SCALE = 10'd960;
    // half of 960*65536, rounds the final divide to nearest
    localparam logic [SUM_W-1:0] OUT_HALF   = 35'd31457280;
    // ceil(65536/15): exact floor(x/15) for x below 4096
    localparam logic [RCP_W-1:0] RCP_15     = 13'd4370;

    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

endpackage

FILE: rtl/rgb_hue_rotate.sv
// Top level of the RGB hue rotation pipeline.
// Rotates the hue of an 8-bit RGB pixel through HSV in fixed point: hue in 1/16 degree,
// saturation Q0.16, the configured signed offset (1/16 degree) added modulo 360 degrees,
// then back to RGB with rounding to nearest and clamping to 0..255. Fully pipelined: one
// pixel per clock sustained while the output is not stalled. The pipe holds the prep
// register, the two 17-step restoring dividers (hue and saturation, one quotient
// bit per stage), then modulo, multiply and rounding stages. The whole pipe
// advances together whenever the output register is empty or being taken; a stall on
// m_tready holds every stage. Write hue_offset only while the pipe is empty.
module rgb_hue_rotate
    import rhr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_we,
    input  logic [OFF_W-1:0] cfg_wdata,    // hue_offset, signed, 1/16 degree
    // input pixels
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,      // red_in [7:0], green_in [15:8], blue_in [23:16]
    // output pixels
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata       // red_out [7:0], green_out [15:8], blue_out [23:16]
);

    logic en;
    logic [OFF_W-1:0] off_reg;

    // whole-pipe advance: output empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= '0;
        end else if (cfg_we) begin
            off_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Prep stage: max/min, hue and saturation dividends and divisors
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r, g, b, mx_next, mn_next, d_next, pa, pb, e;
    logic             red_max, green_max, pge;
    logic [OFF_W-1:0] base;
    logic [22:0]      base_prod, term, hn_next;
    logic [DIV_W-1:0] sn_next;

    always_comb begin
        r = s_tdata[7:0];
        g = s_tdata[15:8];
        b = s_tdata[23:16];
        red_max   = (r >= g) && (r >= b);
        green_max = !red_max && (g >= b);
        mx_next = red_max ? r : (green_max ? g : b);
        mn_next = r;
        if (g < mn_next) mn_next = g;
        if (b < mn_next) mn_next = b;
        d_next = mx_next - mn_next;
        if (red_max) begin
            pa = g;
            pb = b;
        end else if (green_max) begin
            pa = b;
            pb = r;
        end else begin
            pa = r;
            pb = g;
        end
        pge = pa >= pb;
        e   = pge ? pa - pb : pb - pa;
        if (red_max) begin
            base = pge ? 14'd0 : 14'd11520;
        end else if (green_max) begin
            base = 14'd3840;
        end else begin
            base = 14'd7680;
        end
        base_prod = 23'(base * d_next);
        term      = 23'(e * 11'd1920);
        // dividend for round(num / 2d): num + d, never negative
        hn_next   = pge ? base_prod + term + 23'(d_next)
                        : base_prod - term + 23'(d_next);
        sn_next   = {1'b0, d_next, 17'b0} + DIV_W'(mx_next);
    end

    // divider pipe, index 0 is the prep register
    logic             vld_reg [0:DIV_STEPS];
    logic [PIX_W-1:0] mx_reg  [0:DIV_STEPS];
    logic [PIX_W-1:0] d_reg   [0:DIV_STEPS];
    logic [DIV_W-1:0] hr_reg  [0:DIV_STEPS];
    logic [DIV_W-1:0] sr_reg  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] hq_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] sq_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg[0] <= mx_next;
            d_reg[0]  <= d_next;
            hr_reg[0] <= DIV_W'(hn_next);
            sr_reg[0] <= sn_next;
            hq_reg[0] <= '0;
            sq_reg[0] <= '0;
        end
    end

    // one quotient bit per stage, divisor pre-shifted by the bit weight
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - k;
        logic [DIV_W-1:0] hdiv, sdiv;
        logic             hge, sge;

        assign hdiv = DIV_W'({d_reg[k-1], 1'b0}) << SH;
        assign sdiv = DIV_W'({mx_reg[k-1], 1'b0}) << SH;
        assign hge  = hr_reg[k-1] >= hdiv;
        assign sge  = sr_reg[k-1] >= sdiv;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mx_reg[k] <= mx_reg[k-1];
                d_reg[k]  <= d_reg[k-1];
                hr_reg[k] <= hge ? hr_reg[k-1] - hdiv : hr_reg[k-1];
                sr_reg[k] <= sge ? sr_reg[k-1] - sdiv : sr_reg[k-1];
                hq_reg[k] <= {hq_reg[k-1][DIV_STEPS-2:0], hge};
                sq_reg[k] <= {sq_reg[k-1][DIV_STEPS-2:0], sge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: offset and wrap, saturation clamp
    // ------------------------------------------------------------------
    logic [HUE_W-1:0] hue, h_next, h_reg;
    logic [15:0]      hx;
    logic [SAT_W-1:0] s_next, s_reg;
    logic [PIX_W-1:0] mx_a_reg;
    logic             vld_a_reg;

    always_comb begin
        // grey: hue 0; black: saturation 0
        hue = (d_reg[DIV_STEPS] == '0) ? '0 : hq_reg[DIV_STEPS][HUE_W-1:0];
        hx  = 16'(hue) + {{(16-OFF_W){off_reg[OFF_W-1]}}, off_reg} + HUE_WRAP;
        if (hx >= 16'(HUE_FULL * 4)) begin
            h_next = HUE_W'(hx - 16'(HUE_FULL * 4));
        end else if (hx >= 16'(HUE_FULL * 3)) begin
            h_next = HUE_W'(hx - 16'(HUE_FULL * 3));
        end else if (hx >= 16'(HUE_FULL * 2)) begin
            h_next = HUE_W'(hx - 16'(HUE_FULL * 2));
        end else if (hx >= HUE_FULL) begin
            h_next = HUE_W'(hx - HUE_FULL);
        end else begin
            h_next = HUE_W'(hx);
        end
        if (mx_reg[DIV_STEPS] == '0) begin
            s_next = '0;
        end else if (sq_reg[DIV_STEPS][SAT_W]) begin
            s_next = '1;
        end else begin
            s_next = sq_reg[DIV_STEPS][SAT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: chroma product, sector and ramp weight
    // ------------------------------------------------------------------
    logic [CQ_W-1:0]  cq_next, cq_reg;
    logic [HUE_W-1:0] t, f;
    logic [W_W-1:0]   w_next, w_reg;
    sector_t          sect_next, sect_b_reg, sect_c_reg;
    logic [PIX_W-1:0] mx_b_reg;
    logic             vld_b_reg;

    always_comb begin
        cq_next = CQ_W'(mx_a_reg * s_reg);
        if (h_reg >= 13'(HUE_SECTOR * 4)) begin
            t = h_reg - 13'(HUE_SECTOR * 4);
        end else if (h_reg >= 13'(HUE_SECTOR * 2)) begin
            t = h_reg - 13'(HUE_SECTOR * 2);
        end else begin
            t = h_reg;
        end
        f      = (t >= HUE_SECTOR) ? t - HUE_SECTOR : HUE_SECTOR - t;
        w_next = W_W'(HUE_SECTOR - f);
        if (h_reg >= 13'(HUE_SECTOR * 5)) begin
            sect_next = SECT_MR;
        end else if (h_reg >= 13'(HUE_SECTOR * 4)) begin
            sect_next = SECT_BM;
        end else if (h_reg >= 13'(HUE_SECTOR * 3)) begin
            sect_next = SECT_CB;
        end else if (h_reg >= 13'(HUE_SECTOR * 2)) begin
            sect_next = SECT_GC;
        end else if (h_reg >= HUE_SECTOR) begin
            sect_next = SECT_YG;
        end else begin
            sect_next = SECT_RY;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: C, X and m, all scaled by 960*65536
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] cn_next, xn_next, mt_next, cn_reg, xn_reg, mt_reg;
    logic [CQ_W-1:0]   mm;
    logic              vld_c_reg;

    always_comb begin
        mm      = {mx_b_reg, 16'b0} - cq_reg;
        cn_next = PROD_W'(cq_reg * SECT_SCALE);
        xn_next = PROD_W'(cq_reg * w_reg);
        mt_next = PROD_W'(mm * SECT_SCALE);
    end

    // ------------------------------------------------------------------
    // Stage D: channel select, add m and rounding half, drop 2^22
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] c0, c1, c2;
    logic [SUM_W-1:0]  y0, y1, y2;
    logic [Z_W-1:0]    z0_next, z1_next, z2_next, z0_reg, z1_reg, z2_reg;
    logic              vld_d_reg;

    always_comb begin
        unique case (sect_c_reg)
            SECT_RY: begin c0 = cn_reg; c1 = xn_reg; c2 = '0;     end
            SECT_YG: begin c0 = xn_reg; c1 = cn_reg; c2 = '0;     end
            SECT_GC: begin c0 = '0;     c1 = cn_reg; c2 = xn_reg; end
            SECT_CB: begin c0 = '0;     c1 = xn_reg; c2 = cn_reg; end
            SECT_BM: begin c0 = xn_reg; c1 = '0;     c2 = cn_reg; end
            SECT_MR: begin c0 = cn_reg; c1 = '0;     c2 = xn_reg; end
            default: begin c0 = '0;     c1 = '0;     c2 = '0;     end
        endcase
        y0 = SUM_W'(c0) + SUM_W'(mt_reg) + OUT_HALF;
        y1 = SUM_W'(c1) + SUM_W'(mt_reg) + OUT_HALF;
        y2 = SUM_W'(c2) + SUM_W'(mt_reg) + OUT_HALF;
        z0_next = y0[SUM_W-1:22];
        z1_next = y1[SUM_W-1:22];
        z2_next = y2[SUM_W-1:22];
    end

    // ------------------------------------------------------------------
    // Stage E: divide by 15 through reciprocal, clamp, output register
    // ------------------------------------------------------------------
    logic [Z_W+RCP_W-1:0] p0, p1, p2;
    logic [9:0]           q0, q1, q2;
    logic [23:0]          out_next, out_reg;
    logic                 vld_e_reg;

    always_comb begin
        p0 = (Z_W+RCP_W)'(z0_reg * RCP_15);
        p1 = (Z_W+RCP_W)'(z1_reg * RCP_15);
        p2 = (Z_W+RCP_W)'(z2_reg * RCP_15);
        q0 = p0[Z_W+RCP_W-1:16];
        q1 = p1[Z_W+RCP_W-1:16];
        q2 = p2[Z_W+RCP_W-1:16];
        out_next[7:0]   = (q0 > 10'd255) ? 8'hFF : q0[7:0];
        out_next[15:8]  = (q1 > 10'd255) ? 8'hFF : q1[7:0];
        out_next[23:16] = (q2 > 10'd255) ? 8'hFF : q2[7:0];
    end

    // tail pipe registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= vld_reg[DIV_STEPS];
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg      <= h_next;
            s_reg      <= s_next;
            mx_a_reg   <= mx_reg[DIV_STEPS];
            cq_reg     <= cq_next;
            w_reg      <= w_next;
            sect_b_reg <= sect_next;
            mx_b_reg   <= mx_a_reg;
            cn_reg     <= cn_next;
            xn_reg     <= xn_next;
            mt_reg     <= mt_next;
            sect_c_reg <= sect_b_reg;
            z0_reg     <= z0_next;
            z1_reg     <= z1_next;
            z2_reg     <= z2_next;
            out_reg    <= out_next;
        end
    end

    assign m_tvalid = vld_e_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: tb/sv/rgb_hue_rotate_tb.sv
// Self-checking testbench for the RGB hue rotation pipeline.
module rgb_hue_rotate_tb;
    import rhr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [OFF_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;

    rgb_hue_rotate uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    pixel_t      pixel_queue[$];     // pixels waiting to be driven
    pixel_t      rotated_queue[$];   // expected output pixels, oldest first
    logic signed [OFF_W-1:0] hue_shift = '0;  // predictor's copy of hue_offset
    logic        in_taken = 1'b0;    // driven pixel accepted at the last rising edge
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count = 0;

    // Round-half-up divide of the scaled channel sum, clamped to a byte
    function automatic logic [7:0] to_byte(input longint unsigned v);
        longint unsigned q;
        q = (v + 64'd31457280) / 64'd62914560;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Predict the rotated pixel for one input pixel under the current offset
    function automatic pixel_t rotate_pixel(input pixel_t p);
        longint r, g, b, mx, mn, d, num, h, s16, cq, cn, xn, mv, t, f;
        longint c0, c1, c2;
        pixel_t o;
        r = longint'(p.red); g = longint'(p.green); b = longint'(p.blue);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) h = 0;
        else begin
            // red wins ties, then green
            if (mx == r)      num = (g >= b) ? 1920*(g-b) : 11520*d - 1920*(b-g);
            else if (mx == g) num = 3840*d + 1920*(b-r);
            else              num = 7680*d + 1920*(r-g);
            h = (num + d) / (2*d);
        end
        h = (h + longint'(hue_shift)) % 5760;
        if (h < 0) h += 5760;
        if (mx == 0) s16 = 0;
        else begin
            s16 = (d*131072 + mx) / (2*mx);
            if (s16 > 65535) s16 = 65535;
        end
        cq = mx * s16;
        cn = cq * 960;
        t = h % 1920;
        f = (t >= 960) ? t - 960 : 960 - t;
        xn = cq * (960 - f);
        mv = mx * 62914560 - cn;
        case (sector_t'(h / 960))
            SECT_RY: begin c0 = cn; c1 = xn; c2 = 0;  end
            SECT_YG: begin c0 = xn; c1 = cn; c2 = 0;  end
            SECT_GC: begin c0 = 0;  c1 = cn; c2 = xn; end
            SECT_CB: begin c0 = 0;  c1 = xn; c2 = cn; end
            SECT_BM: begin c0 = xn; c1 = 0;  c2 = cn; end
            default: begin c0 = cn; c1 = 0;  c2 = xn; end
        endcase
        o.red = to_byte(c0 + mv);
        o.green = to_byte(c1 + mv);
        o.blue = to_byte(c2 + mv);
        return o;
    endfunction

    // Driver: one pixel per transaction, new data set up on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Input side: predict on accepted transaction (s_tready sampled at the edge)
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            rotated_queue.push_back(rotate_pixel(pixel_t'(s_tdata)));
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        pixel_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = pixel_t'(m_tdata);
            if (rotated_queue.size() == 0) begin
                $error("unexpected output pixel %h", m_tdata);
                fail_count++;
            end else begin
                want = rotated_queue.pop_front();
                if (got.red !== want.red) begin
                    $error("red_out expected %0d got %0d", want.red, got.red);
                    fail_count++;
                end
                if (got.green !== want.green) begin
                    $error("green_out expected %0d got %0d", want.green, got.green);
                    fail_count++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue_out expected %0d got %0d", want.blue, got.blue);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        while (pixel_queue.size() > 0 || s_tvalid || rotated_queue.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Offset written on a falling edge, while the pipe is empty
    task automatic set_offset(input logic [OFF_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        hue_shift = v;
    endtask

    task automatic push_random(input int n);
        pixel_t p;
        repeat (n) begin
            p = 24'($urandom);
            case ($urandom_range(9))
                0: p.green = p.red;                       // tie on red
                1: begin p.green = p.red; p.blue = p.red; end  // grey
                2: p.blue = p.green;
                3: p.blue = p.red;
                default: ;
            endcase
            pixel_queue.push_back(p);
        end
    endtask

    // Stimulus
    initial begin
        logic [OFF_W-1:0] offsets[8];
        offsets = '{14'd0, 14'h1FFF, 14'h2000, 14'd5760, -14'sd5760, 14'd960, -14'sd1, 14'd2};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 24; recv_idle_pct = 54;
        // directed: extremes, greys, each sector, ties for the maximum
        pixel_queue.push_back(24'h000000);
        pixel_queue.push_back(24'hFFFFFF);
        pixel_queue.push_back(24'h808080);
        pixel_queue.push_back(24'h0000FF);
        pixel_queue.push_back(24'h00FF00);
        pixel_queue.push_back(24'hFF0000);
        pixel_queue.push_back(24'h00FFFF);
        pixel_queue.push_back(24'hFFFF00);
        pixel_queue.push_back(24'hFF00FF);
        pixel_queue.push_back(24'h2050FF);
        pixel_queue.push_back(24'h50FF20);
        pixel_queue.push_back(24'hFF2050);
        pixel_queue.push_back(24'h01FF01);
        pixel_queue.push_back(24'h000001);
        pixel_queue.push_back(24'hAA55AA);
        pixel_queue.push_back(24'h55AA55);
        drain();
        foreach (offsets[i]) begin
            set_offset(offsets[i]);
            if (i == 3) begin send_idle_pct = 54; recv_idle_pct = 24; end
            if (i == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
            push_random(210);
            drain();
        end
        if (fail_count == 0)
            $display("rgb_hue_rotate verification clean");
        else
            $display("rgb_hue_rotate verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("rgb_hue_rotate verification failed");
        $finish;
    end

endmodule

FILE: rgb_hue_rotate.f
rtl/rhr_pkg.sv
rtl/rgb_hue_rotate.sv
tb/sv/rgb_hue_rotate_tb.sv
